// ===== rtl/ppmrb_pkg.sv =====
`timescale 1ns / 1ps

package ppmrb_pkg;

	localparam int unsigned NumChannelsDef = 8;
	localparam int unsigned NeutralDef     = 1500;

	localparam int unsigned ChW      = 3;
	localparam int unsigned ValW     = 12;
	localparam int unsigned OffW     = 11;
	localparam int unsigned StepW    = 8;
	localparam int unsigned WaitW    = 16;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned ValMax   = 4095;

	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_MOVE_RAMP  = 5'b00010,
		PH_MOVE_HOLD  = 5'b00100,
		PH_BRAKE_RAMP = 5'b01000,
		PH_BRAKE_HOLD = 5'b10000
	} phase_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} op_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MOVE_OFFSET      = 3'd0,
		REG_MOVE_STEP        = 3'd1,
		REG_MOVE_STEP_TICKS  = 3'd2,
		REG_MOVE_HOLD_TICKS  = 3'd3,
		REG_BRAKE_OFFSET     = 3'd4,
		REG_BRAKE_STEP       = 3'd5,
		REG_BRAKE_STEP_TICKS = 3'd6,
		REG_BRAKE_HOLD_TICKS = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [OffW-1:0]  offset;
		logic [StepW-1:0] step;
		logic [StepW-1:0] step_ticks;
		logic [WaitW-1:0] hold_ticks;
	} ramp_cfg_t;

	typedef struct packed {
		ramp_cfg_t move;
		ramp_cfg_t brake;
	} cfg_t;

	typedef struct packed {
		phase_t           phase;
		logic [ChW-1:0]   chan;
		logic [ValW-1:0]  value;
		logic [WaitW-1:0] wait_cnt;
		logic             dir_up;
		logic             brake_en;
	} seq_state_t;

	typedef struct packed {
		op_t            operation;
		logic [ChW-1:0] channel;
		logic           increase;
		logic           use_brake;
	} cmd_t;

	typedef struct packed {
		logic [ChW-1:0]  active_channel;
		logic [ValW-1:0] pulse_value;
		logic            busy_res;
		logic            sequence_done;
		logic            command_ignored;
	} res_t;

endpackage

// ===== rtl/ppmrb_ifs.sv =====
`timescale 1ns / 1ps

interface ppmrb_cmd_if;
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [ppmrb_pkg::ChW-1:0] channel;
	logic                      increase;
	logic                      use_brake;
	modport source(output valid, operation, channel, increase, use_brake, input ready);
	modport sink(input valid, operation, channel, increase, use_brake, output ready);
endinterface

interface ppmrb_res_if;
	logic                       valid;
	logic                       ready;
	logic [ppmrb_pkg::ChW-1:0]  active_channel;
	logic [ppmrb_pkg::ValW-1:0] pulse_value;
	logic                       busy_res;
	logic                       sequence_done;
	logic                       command_ignored;
	modport source(output valid, active_channel, pulse_value, busy_res, sequence_done,
		command_ignored, input ready);
	modport sink(input valid, active_channel, pulse_value, busy_res, sequence_done,
		command_ignored, output ready);
endinterface

interface ppmrb_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ppmrb_pkg::CfgIdxW-1:0]  index;
	logic [ppmrb_pkg::CfgDataW-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/ppmrb_step.sv =====
`timescale 1ns / 1ps

module ppmrb_step #(
	parameter int unsigned NumChannels  = ppmrb_pkg::NumChannelsDef,
	parameter int unsigned NeutralValue = ppmrb_pkg::NeutralDef
) (
	input  ppmrb_pkg::cfg_t       cfg,
	input  ppmrb_pkg::seq_state_t st,
	input  ppmrb_pkg::cmd_t       cmd,
	output ppmrb_pkg::seq_state_t st_nxt,
	output ppmrb_pkg::res_t       res
);

	localparam int unsigned ValW  = ppmrb_pkg::ValW;
	localparam int unsigned WaitW = ppmrb_pkg::WaitW;
	localparam logic [ValW-1:0] NeutralV = ValW'(NeutralValue);
	localparam logic [ValW:0]   ValMaxW  = (ValW+1)'(ppmrb_pkg::ValMax);
	localparam logic [4:0]      ChLimit  = 5'(NumChannels);

	typedef struct packed {
		logic [ValW-1:0]  value;
		logic [WaitW-1:0] wait_cnt;
		logic             to_hold;
	} ramp_res_t;

	// one ramp action; a zero step interval collapses the whole ramp onto the target
	function automatic ramp_res_t ramp(input logic [ValW-1:0] v, input logic up,
		input ppmrb_pkg::ramp_cfg_t rc);
		logic [ValW:0]   hi;
		logic [ValW-1:0] tgt;
		logic [ValW:0]   sum;
		logic            more;
		ramp_res_t       r;
		hi  = {1'b0, NeutralV} + (ValW+1)'(rc.offset);
		if (up) begin
			tgt = (hi > ValMaxW) ? {ValW{1'b1}} : hi[ValW-1:0];
		end else begin
			tgt = (NeutralV < ValW'(rc.offset)) ? '0 : NeutralV - ValW'(rc.offset);
		end
		more = up ? (v < tgt) : (v > tgt);
		if (rc.step != '0 && more && rc.step_ticks != '0) begin
			sum = {1'b0, v} + (ValW+1)'(rc.step);
			if (up) begin
				r.value = (sum > ValMaxW) ? {ValW{1'b1}} : sum[ValW-1:0];
			end else begin
				r.value = (v < ValW'(rc.step)) ? '0 : v - ValW'(rc.step);
			end
			r.wait_cnt = WaitW'(rc.step_ticks);
			r.to_hold  = 1'b0;
		end else begin
			r.value    = tgt;
			r.wait_cnt = rc.hold_ticks;
			r.to_hold  = 1'b1;
		end
		return r;
	endfunction

	ppmrb_pkg::phase_t ph;
	logic [ValW-1:0]   v;
	logic [WaitW-1:0]  w;
	logic              go;
	logic              done;
	logic              ign;
	ppmrb_pkg::seq_state_t nx;
	ramp_res_t         mr;
	ramp_res_t         br;

	always_comb begin
		nx   = st;
		ph   = st.phase;
		v    = st.value;
		w    = st.wait_cnt;
		go   = 1'b0;
		done = 1'b0;
		ign  = 1'b0;
		mr   = '0;
		br   = '0;
		if (cmd.operation == ppmrb_pkg::OP_START) begin
			if (ph != ppmrb_pkg::PH_IDLE || {2'b00, cmd.channel} >= ChLimit) begin
				ign = 1'b1;
			end else begin
				nx.chan     = cmd.channel;
				nx.dir_up   = cmd.increase;
				nx.brake_en = cmd.use_brake;
				ph          = ppmrb_pkg::PH_MOVE_RAMP;
				w           = '0;
				go          = 1'b1;
			end
		end else if (ph != ppmrb_pkg::PH_IDLE) begin
			if (w != '0) begin
				w = w - WaitW'(1);
			end
			go = (w == '0);
		end
		if (go && ph == ppmrb_pkg::PH_MOVE_RAMP) begin
			mr = ramp(v, nx.dir_up, cfg.move);
			v  = mr.value;
			w  = mr.wait_cnt;
			if (mr.to_hold) begin
				ph = ppmrb_pkg::PH_MOVE_HOLD;
			end
			go = (mr.wait_cnt == '0);
		end
		if (go && ph == ppmrb_pkg::PH_MOVE_HOLD) begin
			if (nx.brake_en) begin
				ph = ppmrb_pkg::PH_BRAKE_RAMP;
			end else begin
				v    = NeutralV;
				ph   = ppmrb_pkg::PH_IDLE;
				w    = '0;
				done = 1'b1;
				go   = 1'b0;
			end
		end
		if (go && ph == ppmrb_pkg::PH_BRAKE_RAMP) begin
			br = ramp(v, !nx.dir_up, cfg.brake);
			v  = br.value;
			w  = br.wait_cnt;
			if (br.to_hold) begin
				ph = ppmrb_pkg::PH_BRAKE_HOLD;
			end
			go = (br.wait_cnt == '0);
		end
		if (go && ph == ppmrb_pkg::PH_BRAKE_HOLD) begin
			v    = NeutralV;
			ph   = ppmrb_pkg::PH_IDLE;
			w    = '0;
			done = 1'b1;
		end
		nx.phase    = ph;
		nx.value    = v;
		nx.wait_cnt = w;
	end

	assign st_nxt              = nx;
	assign res.active_channel  = nx.chan;
	assign res.pulse_value     = nx.value;
	assign res.busy_res        = (nx.phase != ppmrb_pkg::PH_IDLE);
	assign res.sequence_done   = done;
	assign res.command_ignored = ign;

endmodule

// ===== rtl/ppm_channel_ramp_brake_sequencer_unit.sv =====
`timescale 1ns / 1ps

// channel   role    transfer when       payload
// cmd       sink    valid && ready      operation, channel, increase, use_brake
// res       source  valid && ready      active_channel, pulse_value, busy_res,
//                                       sequence_done, command_ignored
// cfg       sink    valid (ready is 1)  index, data
//
// One result per item; it passes the input register, then the result register, and a stalled result side can delay it.
// Input register, then one pass of sequence logic into the result register;
// a new item is taken every cycle while the result side keeps up.
// A stalled result holds; the input register still fills behind it.
// Reset puts every channel at neutral, the sequencer idle and the config registers at defaults.
// Only the active channel can leave neutral, so one value register holds it.

module ppm_channel_ramp_brake_sequencer_unit #(
	parameter int unsigned NUM_CHANNELS  = ppmrb_pkg::NumChannelsDef,
	parameter int unsigned NEUTRAL_VALUE = ppmrb_pkg::NeutralDef
) (
	input  logic   clk,
	input  logic   arst_n,
	ppmrb_cmd_if.sink   cmd,
	ppmrb_res_if.source res,
	ppmrb_cfg_if.sink   cfg
);

	localparam int unsigned ValW = ppmrb_pkg::ValW;

	ppmrb_pkg::cfg_t       cfg_q;
	ppmrb_pkg::seq_state_t st_q;
	ppmrb_pkg::seq_state_t st_nxt;
	ppmrb_pkg::cmd_t       cmd_s1;
	logic                  valid_s1;
	ppmrb_pkg::res_t       res_nxt;
	ppmrb_pkg::res_t       res_s2;
	logic                  valid_s2;
	logic                  advance;
	logic                  cmd_xfer;

	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move.offset      <= ppmrb_pkg::OffW'(200);
			cfg_q.move.step        <= ppmrb_pkg::StepW'(10);
			cfg_q.move.step_ticks  <= ppmrb_pkg::StepW'(10);
			cfg_q.move.hold_ticks  <= ppmrb_pkg::WaitW'(500);
			cfg_q.brake.offset     <= ppmrb_pkg::OffW'(100);
			cfg_q.brake.step       <= ppmrb_pkg::StepW'(10);
			cfg_q.brake.step_ticks <= ppmrb_pkg::StepW'(10);
			cfg_q.brake.hold_ticks <= ppmrb_pkg::WaitW'(200);
		end else if (cfg.valid) begin
			case (ppmrb_pkg::cfg_idx_t'(cfg.index))
				ppmrb_pkg::REG_MOVE_OFFSET:      cfg_q.move.offset      <= cfg.data[ppmrb_pkg::OffW-1:0];
				ppmrb_pkg::REG_MOVE_STEP:        cfg_q.move.step        <= cfg.data[ppmrb_pkg::StepW-1:0];
				ppmrb_pkg::REG_MOVE_STEP_TICKS:  cfg_q.move.step_ticks  <= cfg.data[ppmrb_pkg::StepW-1:0];
				ppmrb_pkg::REG_MOVE_HOLD_TICKS:  cfg_q.move.hold_ticks  <= cfg.data;
				ppmrb_pkg::REG_BRAKE_OFFSET:     cfg_q.brake.offset     <= cfg.data[ppmrb_pkg::OffW-1:0];
				ppmrb_pkg::REG_BRAKE_STEP:       cfg_q.brake.step       <= cfg.data[ppmrb_pkg::StepW-1:0];
				ppmrb_pkg::REG_BRAKE_STEP_TICKS: cfg_q.brake.step_ticks <= cfg.data[ppmrb_pkg::StepW-1:0];
				ppmrb_pkg::REG_BRAKE_HOLD_TICKS: cfg_q.brake.hold_ticks <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase    <= ppmrb_pkg::PH_IDLE;
			st_q.chan     <= '0;
			st_q.value    <= ValW'(NEUTRAL_VALUE);
			st_q.wait_cnt <= '0;
			st_q.dir_up   <= 1'b0;
			st_q.brake_en <= 1'b0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
		end else begin
			if (advance) begin
				st_q <= st_nxt;
			end
			if (cmd_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers: load on transfer, hold otherwise
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			cmd_s1.operation <= ppmrb_pkg::op_t'(cmd.operation);
			cmd_s1.channel   <= cmd.channel;
			cmd_s1.increase  <= cmd.increase;
			cmd_s1.use_brake <= cmd.use_brake;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	ppmrb_step #(
		.NumChannels (NUM_CHANNELS),
		.NeutralValue(NEUTRAL_VALUE)
	) u_step (
		.cfg   (cfg_q),
		.st    (st_q),
		.cmd   (cmd_s1),
		.st_nxt(st_nxt),
		.res   (res_nxt)
	);

	assign res.valid           = valid_s2;
	assign res.active_channel  = res_s2.active_channel;
	assign res.pulse_value     = res_s2.pulse_value;
	assign res.busy_res        = res_s2.busy_res;
	assign res.sequence_done   = res_s2.sequence_done;
	assign res.command_ignored = res_s2.command_ignored;

endmodule

// ===== rtl/ppmrb_checker.sv =====
`timescale 1ns / 1ps

module ppmrb_checker #(
	parameter int unsigned NeutralValue = ppmrb_pkg::NeutralDef
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [ppmrb_pkg::ChW-1:0]  res_channel,
	input logic [ppmrb_pkg::ValW-1:0] res_value,
	input logic                       res_busy,
	input logic                       res_done,
	input logic                       res_ignored
);

	localparam logic [ppmrb_pkg::ValW-1:0] NeutralV = ppmrb_pkg::ValW'(NeutralValue);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_channel)
			&& $stable(res_value) && $stable(res_busy) && $stable(res_done))
		else $error("result changed while stalled");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_done |-> !res_busy)
		else $error("sequence done while still busy");

	a_ignored_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ignored |-> !res_done)
		else $error("ignored command finished a sequence");

	a_idle_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_busy |-> res_value == NeutralV)
		else $error("idle channel not at neutral");

endmodule

bind ppm_channel_ramp_brake_sequencer_unit ppmrb_checker #(
	.NeutralValue(NEUTRAL_VALUE)
) u_ppmrb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_channel(res.active_channel),
	.res_value  (res.pulse_value),
	.res_busy   (res.busy_res),
	.res_done   (res.sequence_done),
	.res_ignored(res.command_ignored)
);
